// File: design/multi_channel_ema_deadband_unit_assert.svh
// assertion macros for the multi-channel ema deadband unit
`ifndef MULTI_CHANNEL_EMA_DEADBAND_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_EMA_DEADBAND_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MCED_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MCED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MCED_ASSERT_SAME(label, ante, cons, msg)
`define MCED_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: design/mced_pkg.sv
// shared constants and types for the multi-channel ema deadband unit
package mced_pkg;

  localparam int CHANNEL_COUNT = 4;
  localparam int SMOOTH_SHIFT  = 2;
  localparam int SAMPLE_BITS   = 12;

  localparam int CH_W     = 2;
  localparam int THR_W    = 12;
  localparam int LAST_W   = SAMPLE_BITS + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);

  typedef logic [THR_W-1:0] thr_arr_t [CHANNEL_COUNT];

  // one sample beat moving into the channel engine
  typedef struct packed {
    logic                   valid;
    logic [CH_W-1:0]        channel;
    logic [SAMPLE_BITS-1:0] sample;
  } item_t;

  // engine outcome for the beat in flight
  typedef struct packed {
    logic                   report;
    logic [CH_W-1:0]        channel;
    logic [SAMPLE_BITS-1:0] value;
  } result_t;

endpackage

// File: design/mced_cfg_regs.sv
// per-channel threshold registers behind the write port
module mced_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mced_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mced_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mced_pkg::thr_arr_t            thr
);
  import mced_pkg::*;

  thr_arr_t thr_r;

  // write the addressed threshold, ignore indexes past the list
  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (!rst_n) begin
        thr_r[i] <= THR_RESET;
      end else if (cfg_we && (int'(cfg_index) == i)) begin
        thr_r[i] <= cfg_wdata[THR_W-1:0];
      end
    end
  end

  assign thr = thr_r;

endmodule

// File: design/mced_chan_engine.sv
// per-channel smoothing state, ema update and deadband decision
module mced_chan_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  mced_pkg::item_t     item,
  input  mced_pkg::thr_arr_t  thr,
  output mced_pkg::result_t   res
);
  import mced_pkg::*;

  logic [SAMPLE_BITS-1:0] sm_r   [CHANNEL_COUNT];
  logic [LAST_W-1:0]      last_r [CHANNEL_COUNT];
  logic                   seed_r [CHANNEL_COUNT];

  logic                     in_range;
  logic [SAMPLE_BITS-1:0]   cur_sm;
  logic [LAST_W-1:0]        cur_last;
  logic                     cur_seed;
  logic signed [SAMPLE_BITS:0]   delta;
  logic signed [SAMPLE_BITS:0]   step;
  logic signed [SAMPLE_BITS:0]   sum;
  logic [SAMPLE_BITS-1:0]   new_sm;
  logic signed [SAMPLE_BITS+1:0] dev;
  logic [SAMPLE_BITS+1:0]   dev_abs;
  logic                     hit;
  logic                     upd;

  assign in_range = (int'(item.channel) < CHANNEL_COUNT);
  assign cur_sm   = sm_r[item.channel];
  assign cur_last = last_r[item.channel];
  assign cur_seed = seed_r[item.channel];

  // ema update, arithmetic shift floors negative steps
  always_comb begin
    delta = $signed({1'b0, item.sample}) - $signed({1'b0, cur_sm});
    step  = delta >>> SMOOTH_SHIFT;
    sum   = $signed({1'b0, cur_sm}) + step;
    new_sm = cur_seed ? sum[SAMPLE_BITS-1:0] : item.sample;
  end

  // distance from the last reported value against the threshold
  always_comb begin
    dev     = $signed({2'b00, new_sm}) - $signed({cur_last[LAST_W-1], cur_last});
    dev_abs = dev[SAMPLE_BITS+1] ? (SAMPLE_BITS+2)'(-dev) : dev;
    hit     = (dev_abs >= (SAMPLE_BITS+2)'(thr[item.channel]));
  end

  assign upd = item.valid && in_range;

  assign res.report  = upd && hit;
  assign res.channel = item.channel;
  assign res.value   = new_sm;

  // state write for the beat in flight
  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (!rst_n) begin
        sm_r[i]   <= '0;
        last_r[i] <= '1;
        seed_r[i] <= 1'b0;
      end else if (upd && (int'(item.channel) == i)) begin
        sm_r[i]   <= new_sm;
        seed_r[i] <= 1'b1;
        if (hit) begin
          last_r[i] <= {1'b0, new_sm};
        end
      end
    end
  end

endmodule

// File: design/multi_channel_ema_deadband_unit.sv
// top level of the multi-channel ema deadband unit
// Usage:
//   Input channel: in_valid / in_stall carry one beat of (in_channel, in_sample).
//   The first sample of a channel seeds its smoothed value; later samples
//   move it by a quarter of the difference, floored.
//   Output channel: out_valid / out_stall carry a beat of (out_report_channel,
//   out_report_value) whenever a channel drifts from its last reported value
//   by at least its threshold. Samples that do not qualify give no beat.
//   Config: cfg_we writes cfg_wdata into threshold register cfg_index
//   (channels 0..3); write only while the block is idle.
// Timing:
//   A sample accepted into the input register is loaded into the result
//   register once that register is free or drains, so out_valid comes
//   straight from the result register. One sample per cycle is sustained
//   while out_stall does not hold a pending result; the limit is the
//   per-channel read-modify-write of the smoothed and last reported state.
// Reset (rst_n low, synchronous): thresholds return to 16, all channels
//   unseeded, last reported = -1 so a first value >= threshold - 1 is reported.
// Stall: while out_stall holds a pending result, the sample in the input
//   register waits and in_stall rises once that register is full.
module multi_channel_ema_deadband_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mced_pkg::CH_W-1:0]        in_channel,
  input  logic [mced_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mced_pkg::CH_W-1:0]        out_report_channel,
  output logic [mced_pkg::SAMPLE_BITS-1:0] out_report_value,
  input  logic                            cfg_we,
  input  logic [mced_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mced_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mced_pkg::*;
`include "multi_channel_ema_deadband_unit_assert.svh"

  logic                   in_valid_r;
  logic [CH_W-1:0]        in_channel_r;
  logic [SAMPLE_BITS-1:0] in_sample_r;
  logic                   out_valid_r;
  logic [CH_W-1:0]        out_channel_r;
  logic [SAMPLE_BITS-1:0] out_value_r;

  logic     advance;
  logic     in_take;
  logic     res_fire;
  item_t    item;
  result_t  res;
  thr_arr_t thr;

  // the held sample moves on once the result register is free or drains
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign res_fire = res.report;

  assign item.valid   = advance;
  assign item.channel = in_channel_r;
  assign item.sample  = in_sample_r;

  mced_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .thr       (thr)
  );

  mced_chan_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .thr   (thr),
    .res   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_channel_r <= in_channel;
      in_sample_r  <= in_sample;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_channel_r <= res.channel;
      out_value_r   <= res.value;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_report_channel = out_channel_r;
  assign out_report_value   = out_value_r;

  // checks
  `MCED_ASSERT_NEXT(a_fire_loads, res_fire, out_valid && (out_report_channel == $past(in_channel_r)), "report beat not loaded")
  `MCED_ASSERT_NEXT(a_drain, out_valid_r && !out_stall && !res_fire, !out_valid_r, "result beat repeated")
  `MCED_ASSERT_NEXT(a_hold_sample, in_valid_r && out_valid_r && out_stall, in_valid_r && $stable(in_sample_r), "held sample lost")
  `MCED_ASSERT_SAME(a_fire_needs_room, res_fire, !out_valid_r || !out_stall, "result overwrote pending beat")

endmodule
